// ===== rtl/hnre_pkg.sv =====
// Package for the HTML numeric character reference encoder.
// Holds the request/result structs, character codes, register indexes and the digit split.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hnre_pkg;

    // Headroom kept free in the destination on top of the "&#" prefix.
    localparam int unsigned RESERVE = 16;
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_BYTES = 1'd1;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 16'd128;

    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } hnre_in_t;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             out_last;
        logic             failed;
        logic [CNT_W-1:0] length;
    } hnre_out_t;

    // One queued result; length is kept once per request, not per entry.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       failed;
    } hnre_entry_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } hnre_digits_t;

    // Split a value of 0..255 into decimal digits.
    // Tens come from a multiply by 205 and shift by 11, exact below 1029.
    function automatic hnre_digits_t split_digits(input logic [7:0] mag);
        hnre_digits_t d;
        logic [7:0]   rem;
        logic [17:0]  prod;
        begin
            if (mag >= 8'd200) begin
                d.hundreds = 4'd2;
                rem = mag - 8'd200;
            end else if (mag >= 8'd100) begin
                d.hundreds = 4'd1;
                rem = mag - 8'd100;
            end else begin
                d.hundreds = 4'd0;
                rem = mag;
            end
            prod = 18'(rem) * 18'd205;
            d.tens = prod[14:11];
            d.ones = 4'(rem - 8'(d.tens) * 8'd10);
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/html_numeric_reference_encoder.sv =====
// Top level of the HTML numeric character reference encoder.
// Depends on hnre_pkg for structs, character codes and the digit split.
// Latency: the first result of a request is presented the cycle after its acceptance.
// Throughput: one result per cycle while m_ready is high; a request queues as many
// results as it yields (0 when absorbed, 1 on failure, 4 to 8 when encoded).
// Reset (aresetn low, synchronous): capacity 128, signed mode on, count and fail flag cleared.
`timescale 1ns / 1ps
`default_nettype none

module html_numeric_reference_encoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [hnre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hnre_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire hnre_pkg::hnre_in_t                  s_payload,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output hnre_pkg::hnre_out_t                      m_payload
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [hnre_pkg::CNT_W-1:0] capacity_reg;
    logic                       signed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= hnre_pkg::CAPACITY_RESET;
            signed_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hnre_pkg::CFG_CAPACITY:     capacity_reg <= cfg_wdata;
                hnre_pkg::CFG_SIGNED_BYTES: signed_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // String state and result queue
    // ------------------------------------------------------------------
    logic [hnre_pkg::CNT_W-1:0] out_count_reg, out_count_next;
    logic                       fail_latch_reg, fail_latch_next;

    // Results of the request in flight; read out one per cycle while m_ready is high.
    hnre_pkg::hnre_entry_t      seq_reg [hnre_pkg::MAX_RESULTS];
    hnre_pkg::hnre_entry_t      seq_next [hnre_pkg::MAX_RESULTS];
    logic [hnre_pkg::CNT_W-1:0] len_reg, len_next;
    logic [2:0]                 idx_reg;
    logic [3:0]                 left_reg, seq_count;

    logic s_fire, m_fire;
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // Take a new request when the queue is empty or its final result leaves now.
    assign s_ready = (left_reg == 4'd0) || (left_reg == 4'd1 && m_ready);

    // ------------------------------------------------------------------
    // Encode one request into its result sequence
    // ------------------------------------------------------------------
    logic                       neg;
    logic [7:0]                 mag;
    hnre_pkg::hnre_digits_t     dig;
    logic [16:0]                need;
    logic                       cap_fail;
    logic [3:0]                 pos;
    logic [hnre_pkg::CNT_W-1:0] sum_count;

    always_comb begin
        neg  = signed_reg && s_payload.byte_in[7];
        // 256 - b fits 8 bits for b in 128..255 as the two's complement negation
        mag  = neg ? (8'd0 - s_payload.byte_in) : s_payload.byte_in;
        dig  = hnre_pkg::split_digits(mag);
        need = {1'b0, out_count_reg} + 17'(2 + hnre_pkg::RESERVE);
        cap_fail = (need >= {1'b0, capacity_reg});

        for (int i = 0; i < int'(hnre_pkg::MAX_RESULTS); i++) begin
            seq_next[i] = '0;
        end
        pos             = 4'd0;
        sum_count       = out_count_reg;
        len_next        = '0;
        out_count_next  = out_count_reg;
        fail_latch_next = fail_latch_reg;

        if (fail_latch_reg) begin
            // Absorb the rest of a failed string; its last byte rearms the encoder.
            if (s_payload.last_byte) begin
                fail_latch_next = 1'b0;
                out_count_next  = '0;
            end
        end else if (cap_fail) begin
            seq_next[0] = '{ch: hnre_pkg::CHAR_NUL, last: 1'b1, failed: 1'b1};
            pos = 4'd1;
            if (s_payload.last_byte) begin
                out_count_next = '0;
            end else begin
                fail_latch_next = 1'b1;
            end
        end else begin
            seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_AMP, last: 1'b0, failed: 1'b0};
            pos = pos + 4'd1;
            seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_HASH, last: 1'b0, failed: 1'b0};
            pos = pos + 4'd1;
            if (neg) begin
                seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_MINUS, last: 1'b0, failed: 1'b0};
                pos = pos + 4'd1;
            end
            if (mag >= 8'd100) begin
                seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_ZERO + 8'(dig.hundreds),
                                       last: 1'b0, failed: 1'b0};
                pos = pos + 4'd1;
            end
            if (mag >= 8'd10) begin
                seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_ZERO + 8'(dig.tens),
                                       last: 1'b0, failed: 1'b0};
                pos = pos + 4'd1;
            end
            seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_ZERO + 8'(dig.ones),
                                   last: 1'b0, failed: 1'b0};
            pos = pos + 4'd1;
            seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_SEMI, last: 1'b0, failed: 1'b0};
            pos = pos + 4'd1;

            sum_count      = out_count_reg + hnre_pkg::CNT_W'(pos);
            out_count_next = sum_count;

            // Terminator carries the final length and closes the string.
            if (s_payload.last_byte) begin
                seq_next[pos[2:0]] = '{ch: hnre_pkg::CHAR_NUL, last: 1'b1, failed: 1'b0};
                pos            = pos + 4'd1;
                len_next       = sum_count;
                out_count_next = '0;
            end
        end
        seq_count = pos;
    end

    // Control state: count, fail flag, queue position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_count_reg  <= '0;
            fail_latch_reg <= 1'b0;
            idx_reg        <= '0;
            left_reg       <= '0;
        end else if (s_fire) begin
            // load wins over drain: the drained result was the final one anyway
            out_count_reg  <= out_count_next;
            fail_latch_reg <= fail_latch_next;
            idx_reg        <= '0;
            left_reg       <= seq_count;
        end else if (m_fire) begin
            idx_reg  <= idx_reg + 3'd1;
            left_reg <= left_reg - 4'd1;
        end
    end

    // Payload of the queue: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < int'(hnre_pkg::MAX_RESULTS); i++) begin
                seq_reg[i] <= seq_next[i];
            end
            len_reg <= len_next;
        end
    end

    // ------------------------------------------------------------------
    // Result port: present the queue head
    // ------------------------------------------------------------------
    hnre_pkg::hnre_entry_t head;

    always_comb begin
        head                = seq_reg[idx_reg];
        m_valid             = (left_reg != 4'd0);
        m_payload.out_char  = head.ch;
        m_payload.out_last  = head.last;
        m_payload.failed    = head.failed;
        // length only rides on the terminator
        m_payload.length    = (head.last && !head.failed) ? len_reg : '0;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An absorbed byte queues no result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && fail_latch_reg |=> !m_valid)
        else $error("absorbed byte produced a result");

    // The closing result of a string is always the last one queued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.out_last |-> left_reg == 4'd1)
        else $error("closing result is not at the end of the queue");

    // A request never queues more than the maximum number of results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> left_reg <= 4'(hnre_pkg::MAX_RESULTS))
        else $error("result queue overfilled");

    // A failure that does not end the string keeps the count and arms the absorb flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !fail_latch_reg && cap_fail && !s_payload.last_byte |=> fail_latch_reg)
        else $error("failure did not arm absorbing");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for html_numeric_reference_encoder: encodes byte strings and checks every character.
// Depends on hnre_pkg and the encoder RTL; a built-in predictor supplies the expected characters.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned RUN_LIMIT = 300000;   // cycles before the run is declared hung
    localparam int unsigned IDLE_PCT = 22;        // percent of cycles each side idles
    localparam int unsigned HOLD_AT = 400;        // result count that triggers the long stall
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 4;    // covers absorbed requests still in flight

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [hnre_pkg::CFG_IDX_W-1:0]  cfg_index = hnre_pkg::CFG_CAPACITY;
    logic [hnre_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    hnre_pkg::hnre_in_t              s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    hnre_pkg::hnre_out_t             m_payload;

    html_numeric_reference_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Predictor state: a private copy of the registers and of the string bookkeeping.
    logic [15:0] capacity_reg = hnre_pkg::CAPACITY_RESET;
    logic        signed_mode = 1'b1;
    logic [15:0] chars_in_string = '0;
    logic        string_failed = 1'b0;

    hnre_pkg::hnre_in_t  pending_requests[$];
    hnre_pkg::hnre_out_t expected_chars[$];

    int unsigned accepted_requests = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // Both sides run flat out while this window of requests goes through.
    wire steady = (accepted_requests >= 100) && (accepted_requests < 160);

    // Work out the characters one accepted request yields and queue them; return their count.
    function automatic int encode_request(hnre_pkg::hnre_in_t req);
        hnre_pkg::hnre_out_t r;
        logic [7:0]          mag;
        logic                neg;
        int                  n;
        n = 0;
        r = '0;
        if (string_failed) begin
            // Swallow the rest of a failed string; its last byte rearms the encoder.
            if (req.last_byte) begin
                string_failed = 1'b0;
                chars_in_string = '0;
            end
            return 0;
        end
        if (int'(chars_in_string) + 2 + int'(hnre_pkg::RESERVE) >= int'(capacity_reg)) begin
            r.out_char = hnre_pkg::CHAR_NUL;
            r.out_last = 1'b1;
            r.failed = 1'b1;
            r.length = '0;
            expected_chars.push_back(r);
            if (req.last_byte) chars_in_string = '0;
            else string_failed = 1'b1;
            return 1;
        end
        neg = signed_mode && req.byte_in[7];
        mag = neg ? 8'(9'd256 - {1'b0, req.byte_in}) : req.byte_in;
        r.out_char = hnre_pkg::CHAR_AMP;  expected_chars.push_back(r); n++;
        r.out_char = hnre_pkg::CHAR_HASH; expected_chars.push_back(r); n++;
        if (neg) begin
            r.out_char = hnre_pkg::CHAR_MINUS; expected_chars.push_back(r); n++;
        end
        if (mag >= 100) begin
            r.out_char = hnre_pkg::CHAR_ZERO + 8'(mag / 100);
            expected_chars.push_back(r); n++;
        end
        if (mag >= 10) begin
            r.out_char = hnre_pkg::CHAR_ZERO + 8'((mag / 10) % 10);
            expected_chars.push_back(r); n++;
        end
        r.out_char = hnre_pkg::CHAR_ZERO + 8'(mag % 10); expected_chars.push_back(r); n++;
        r.out_char = hnre_pkg::CHAR_SEMI; expected_chars.push_back(r); n++;
        chars_in_string = chars_in_string + 16'(n);
        if (req.last_byte) begin
            // Terminator carries the length of the finished string.
            r.out_char = hnre_pkg::CHAR_NUL;
            r.out_last = 1'b1;
            r.length = chars_in_string;
            expected_chars.push_back(r);
            n++;
            chars_in_string = '0;
        end
        return n;
    endfunction

    // Request driver: predict on acceptance, then offer the next pending request or idle.
    always @(posedge aclk) begin : drive_requests
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_payload <= '0;
        end else begin
            if (s_valid && s_ready) begin
                void'(encode_request(s_payload));
                accepted_requests++;
            end
            // Hold valid and payload until the request is taken.
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_payload <= pending_requests.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(hnre_pkg::hnre_out_t want, hnre_pkg::hnre_out_t got,
                                   bit orphan);
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan)
                $display("[%0t] unexpected result: char %h last %b failed %b length %0d",
                         $realtime, got.out_char, got.out_last, got.failed, got.length);
            else
                $display("[%0t] result %0d: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                         $realtime, results_seen, want.out_char, want.out_last, want.failed,
                         want.length, got.out_char, got.out_last, got.failed, got.length);
        end
    endtask

    // Result monitor: compare each accepted character with the oldest expectation.
    always @(posedge aclk) begin : check_results
        hnre_pkg::hnre_out_t want;
        int unsigned         hold_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    report_mismatch('0, m_payload, 1'b1);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_payload.out_char !== want.out_char ||
                        m_payload.out_last !== want.out_last ||
                        m_payload.failed   !== want.failed ||
                        m_payload.length   !== want.length)
                        report_mismatch(want, m_payload, 1'b0);
                end
                // Stall the output once for a long stretch so the encoder backs up.
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Hang guard.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Wait until every request is taken and every character has come back.
    task automatic settle();
        while (pending_requests.size() != 0 || s_valid || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; only call while the encoder is idle.
    task automatic write_reg(logic [hnre_pkg::CFG_IDX_W-1:0] idx,
                             logic [hnre_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == hnre_pkg::CFG_CAPACITY) capacity_reg = value;
        else if (idx == hnre_pkg::CFG_SIGNED_BYTES) signed_mode = value[0];
    endtask

    task automatic push_request(logic [7:0] b, logic last);
        hnre_pkg::hnre_in_t req;
        req.byte_in = b;
        req.last_byte = last;
        pending_requests.push_back(req);
    endtask

    // Favor the digit-count and sign boundaries, otherwise any byte.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corner[8];
        corner = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd127, 8'd128, 8'd255};
        if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Feed random strings until about target requests have been queued.
    task automatic run_strings(int unsigned target, int unsigned max_len);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < target) begin
            while (pending_requests.size() > 4) @(posedge aclk);
            // Mostly short strings; now and then an overlong one to hit the capacity check.
            if ($urandom_range(0, 9) == 0) len = $urandom_range(max_len, 2 * max_len + 20);
            else len = $urandom_range(1, max_len);
            for (int unsigned i = 0; i < len; i++)
                push_request(pick_byte(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-byte strings at the reset setting: digit counts and signed wrap.
        push_request(8'd0, 1'b1);
        push_request(8'd1, 1'b1);
        push_request(8'd9, 1'b1);
        push_request(8'd10, 1'b1);
        push_request(8'd99, 1'b1);
        push_request(8'd100, 1'b1);
        push_request(8'd127, 1'b1);
        push_request(8'd128, 1'b1);
        push_request(8'd129, 1'b1);
        push_request(8'd200, 1'b1);
        push_request(8'd255, 1'b1);
        // Multi-byte string; length accumulates across bytes.
        push_request(8'd65, 1'b0);
        push_request(8'd200, 1'b0);
        push_request(8'd7, 1'b0);
        push_request(8'd255, 1'b1);
        settle();

        // Tight capacity: first byte fits, the second fails, the rest is absorbed.
        write_reg(hnre_pkg::CFG_CAPACITY, 16'd23);
        push_request(8'd48, 1'b0);
        push_request(8'd49, 1'b0);
        push_request(8'd50, 1'b0);
        push_request(8'd51, 1'b1);
        // Failure landing on the last byte itself.
        push_request(8'd48, 1'b0);
        push_request(8'd49, 1'b1);
        // The encoder must be rearmed for a fresh string.
        push_request(8'd52, 1'b1);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'hFFFF);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd0);
        run_strings(45, 6);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'd40);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd1);
        run_strings(30, 6);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'd128);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd0);
        run_strings(40, 8);
        settle();

        // Capacity too small for anything: every string fails on its first byte.
        write_reg(hnre_pkg::CFG_CAPACITY, 16'd1);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd1);
        run_strings(12, 4);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'd0);
        run_strings(8, 3);
        settle();

        // Either side of the first-byte boundary.
        write_reg(hnre_pkg::CFG_CAPACITY, 16'd19);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd0);
        run_strings(16, 3);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'd18);
        run_strings(8, 3);
        settle();

        write_reg(hnre_pkg::CFG_CAPACITY, 16'd300);
        write_reg(hnre_pkg::CFG_SIGNED_BYTES, 16'd1);
        run_strings(55, 10);
        settle();

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
